// ----- sv/nfa_pkg.sv -----
// shared types and codes for the nfa subset construction block
package nfa_pkg;

   localparam int SET_W    = 16;
   localparam int STATE_W  = 4;
   localparam int CODE_W   = 8;
   localparam int CMD_W    = 3;
   localparam int KIND_W   = 3;
   localparam int CSR_IDX_W = 1;

   // visited bitmap kept as rows of 16 bits
   localparam int VIS_BIT_W = 4;
   localparam int VIS_ROW_W = 16;
   localparam int VIS_AW    = SET_W - VIS_BIT_W;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LETTER = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TRANS  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STEP   = 3'd4;

   localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TRANS   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSED  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SKIPPED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OVF     = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_MASK  = 1'd1;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [CODE_W-1:0]  letter_code;
      logic [STATE_W-1:0] from_state;
      logic [STATE_W-1:0] to_state;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SET_W-1:0]  from_set;
      logic [CODE_W-1:0] edge_letter;
      logic [SET_W-1:0]  to_set;
      logic              from_is_final;
      logic              last;
   } rsp_type;

endpackage

// ----- sv/nfa_ram.sv -----
// generic simple dual port ram with registered read
module nfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/nfa_subset_construction.sv -----
// nfa to dfa subset construction engine with table, visited map and subset queue in ram
// One command beat in, one or more result beats out. Loading commands (clear,
// add letter, add transition) and start each answer with one ack beat (an
// overflow beat for a new letter when the alphabet is full); a step pops one
// subset and answers with a skip beat, a queue empty beat, or one transition
// beat per letter with a nonempty successor set (an overflow beat if it must be
// queued and the queue is full) followed by a closed beat. The successor table
// is one ram row per nfa state holding all letters, so a step reads NFA_STATES
// rows (one a cycle) and then walks the letters, with one visited lookup per
// nonempty successor. The visited bitmap lives in a 4096 x 16 ram; after reset
// and on every start command a clearing pass walks all 4096 rows, and no command
// beat is taken until the pass ends (csr writes are always taken). A transition
// add is a read-modify-write of one table row.
module nfa_subset_construction
   import nfa_pkg::*;
#(
   parameter int NFA_STATES  = 16,
   parameter int LETTERS     = 8,
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   // command channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // register writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SET_W-1:0]     csr_wdata
);

   localparam int SW    = $clog2(NFA_STATES);
   localparam int LW    = (LETTERS > 1) ? $clog2(LETTERS) : 1;
   localparam int LCW   = $clog2(LETTERS + 1);
   localparam int QW    = $clog2(QUEUE_DEPTH);
   localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
   localparam int ROW_W = LETTERS * SET_W;

   typedef enum logic [9:0] {
      S_SWEEP = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_ACK   = 10'b0000000100,
      S_TRN   = 10'b0000001000,
      S_POP   = 10'b0000010000,
      S_VIS   = 10'b0000100000,
      S_ACC   = 10'b0001000000,
      S_LET   = 10'b0010000000,
      S_LCHK  = 10'b0100000000,
      S_CLOSE = 10'b1000000000
   } fsm_type;

   // control state
   fsm_type state_ff, state_in;
   logic [STATE_W-1:0] start_state_ff, start_state_in;
   logic [SET_W-1:0]   final_mask_ff, final_mask_in;
   logic [LCW-1:0]     letter_count_ff, letter_count_in;
   logic [NFA_STATES-1:0] succ_vld_ff, succ_vld_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [QW-1:0]      q_head_ff, q_head_in;
   logic [QW-1:0]      q_tail_ff, q_tail_in;
   logic [QCW-1:0]     q_count_ff, q_count_in;
   logic [VIS_AW-1:0]  sweep_ff, sweep_in;
   logic               sweep_ack_ff, sweep_ack_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   logic [CODE_W-1:0]  letter_ff [LETTERS];
   logic [KIND_W-1:0]  pend_kind_ff, pend_kind_in;
   logic [SET_W-1:0]   cur_ff, cur_in;
   logic [SW-1:0]      s_ff, s_in;
   logic [SET_W-1:0]   acc_ff [LETTERS];
   logic [SET_W-1:0]   acc_in [LETTERS];
   logic [LCW-1:0]     li_ff, li_in;
   logic [SET_W-1:0]   trn_bit_ff, trn_bit_in;
   logic [LW-1:0]      trn_li_ff, trn_li_in;
   logic [SW-1:0]      trn_from_ff, trn_from_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // letter table write
   logic               letter_we;

   // ram ports
   logic              s_we, s_re;
   logic [SW-1:0]     s_waddr, s_raddr;
   logic [ROW_W-1:0]  s_wdata, s_rdata;
   logic              q_we, q_re;
   logic [QW-1:0]     q_waddr, q_raddr;
   logic [SET_W-1:0]  q_wdata, q_rdata;
   logic              v_we, v_re;
   logic [VIS_AW-1:0] v_waddr, v_raddr;
   logic [VIS_ROW_W-1:0] v_wdata, v_rdata;

   // helpers
   logic              req_take;
   logic              out_free;
   logic              hit_found;
   logic [LW-1:0]     hit_idx;
   logic              from_ok, to_ok;
   logic [SET_W-1:0]  seed;
   logic [SET_W-1:0]  next_set;
   logic [ROW_W-1:0]  row_old;
   logic              q_full;
   logic              q_push;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign from_ok  = {1'b0, req_data.from_state} < (STATE_W + 1)'(NFA_STATES);
   assign to_ok    = {1'b0, req_data.to_state} < (STATE_W + 1)'(NFA_STATES);
   assign seed     = ({1'b0, start_state_ff} < (STATE_W + 1)'(NFA_STATES)) ?
                     (SET_W'(1) << start_state_ff) : '0;
   assign next_set = acc_ff[li_ff[LW-1:0]];
   assign row_old  = rd_vld_ff ? s_rdata : '0;
   assign q_full   = (q_count_ff == QCW'(QUEUE_DEPTH));

   // alphabet lookup over the filled letter slots
   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      for (int i = 0; i < LETTERS; i++) begin
         if (LCW'(i) < letter_count_ff && letter_ff[i] == req_data.letter_code &&
             !hit_found) begin
            hit_found = 1'b1;
            hit_idx   = LW'(i);
         end
      end
   end

   // main sequencer
   always_comb begin
      state_in        = state_ff;
      start_state_in  = start_state_ff;
      final_mask_in   = final_mask_ff;
      letter_count_in = letter_count_ff;
      succ_vld_in     = succ_vld_ff;
      rd_vld_in       = rd_vld_ff;
      q_head_in       = q_head_ff;
      q_tail_in       = q_tail_ff;
      q_count_in      = q_count_ff;
      sweep_in        = sweep_ff;
      sweep_ack_in    = sweep_ack_ff;
      pend_kind_in    = pend_kind_ff;
      cur_in          = cur_ff;
      s_in            = s_ff;
      acc_in          = acc_ff;
      li_in           = li_ff;
      trn_bit_in      = trn_bit_ff;
      trn_li_in       = trn_li_ff;
      trn_from_in     = trn_from_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      letter_we       = 1'b0;
      q_push          = 1'b0;

      s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
      q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;
      v_we = 1'b0; v_waddr = '0; v_wdata = '0; v_re = 1'b0; v_raddr = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_STATE: start_state_in = csr_wdata[STATE_W-1:0];
            CSR_FINAL_MASK:  final_mask_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_SWEEP: begin
            // clearing pass over the visited rows
            v_we     = 1'b1;
            v_waddr  = sweep_ff;
            v_wdata  = '0;
            sweep_in = sweep_ff + VIS_AW'(1);
            if (sweep_ff == '1) begin
               state_in     = sweep_ack_ff ? S_ACK : S_IDLE;
               sweep_ack_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               pend_kind_in = KIND_ACK;
               state_in     = S_ACK;
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     succ_vld_in     = '0;
                     letter_count_in = '0;
                  end
                  CMD_LETTER: begin
                     if (!hit_found) begin
                        if (letter_count_ff >= LCW'(LETTERS)) begin
                           pend_kind_in = KIND_OVF;
                        end else begin
                           letter_we       = 1'b1;
                           letter_count_in = letter_count_ff + LCW'(1);
                        end
                     end
                  end
                  CMD_TRANS: begin
                     if (hit_found && from_ok && to_ok) begin
                        s_re        = 1'b1;
                        s_raddr     = req_data.from_state[SW-1:0];
                        rd_vld_in   = succ_vld_ff[req_data.from_state[SW-1:0]];
                        trn_bit_in  = SET_W'(1) << req_data.to_state;
                        trn_li_in   = hit_idx;
                        trn_from_in = req_data.from_state[SW-1:0];
                        state_in    = S_TRN;
                     end
                  end
                  CMD_START: begin
                     // queue restarts holding the seed subset
                     q_we         = 1'b1;
                     q_waddr      = '0;
                     q_wdata      = seed;
                     q_head_in    = '0;
                     q_tail_in    = QW'(1);
                     q_count_in   = QCW'(1);
                     sweep_in     = '0;
                     sweep_ack_in = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  CMD_STEP: begin
                     if (q_count_ff == '0) begin
                        pend_kind_in = KIND_EMPTY;
                     end else begin
                        q_re       = 1'b1;
                        q_raddr    = q_head_ff;
                        q_head_in  = (q_head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 :
                                     q_head_ff + QW'(1);
                        q_count_in = q_count_ff - QCW'(1);
                        state_in   = S_POP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TRN: begin
            s_we    = 1'b1;
            s_waddr = trn_from_ff;
            s_wdata = row_old | (ROW_W'(trn_bit_ff) << (trn_li_ff * SET_W));
            succ_vld_in[trn_from_ff] = 1'b1;
            state_in = S_ACK;
         end
         S_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{kind: pend_kind_ff, from_set: '0, edge_letter: '0,
                                to_set: '0, from_is_final: 1'b0, last: 1'b1};
               state_in     = S_IDLE;
            end
         end
         S_POP: begin
            cur_in   = q_rdata;
            v_re     = 1'b1;
            v_raddr  = q_rdata[SET_W-1:VIS_BIT_W];
            state_in = S_VIS;
         end
         S_VIS: begin
            if (v_rdata[cur_ff[VIS_BIT_W-1:0]]) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{kind: KIND_SKIPPED, from_set: cur_ff,
                                   edge_letter: '0, to_set: '0,
                                   from_is_final: |(cur_ff & final_mask_ff),
                                   last: 1'b1};
                  state_in     = S_IDLE;
               end
            end else begin
               // mark visited, then sweep the member rows
               v_we    = 1'b1;
               v_waddr = cur_ff[SET_W-1:VIS_BIT_W];
               v_wdata = v_rdata | (VIS_ROW_W'(1) << cur_ff[VIS_BIT_W-1:0]);
               for (int l = 0; l < LETTERS; l++) begin
                  acc_in[l] = '0;
               end
               s_in      = '0;
               s_re      = 1'b1;
               s_raddr   = '0;
               rd_vld_in = succ_vld_ff[0];
               state_in  = S_ACC;
            end
         end
         S_ACC: begin
            if (cur_ff[s_ff] && rd_vld_ff) begin
               for (int l = 0; l < LETTERS; l++) begin
                  acc_in[l] = acc_ff[l] | s_rdata[l*SET_W +: SET_W];
               end
            end
            if (s_ff == SW'(NFA_STATES - 1)) begin
               li_in    = '0;
               state_in = S_LET;
            end else begin
               s_in      = s_ff + SW'(1);
               s_re      = 1'b1;
               s_raddr   = s_ff + SW'(1);
               rd_vld_in = succ_vld_ff[s_ff + SW'(1)];
            end
         end
         S_LET: begin
            if (li_ff >= letter_count_ff) begin
               state_in = S_CLOSE;
            end else if (next_set == '0) begin
               li_in = li_ff + LCW'(1);
            end else begin
               v_re     = 1'b1;
               v_raddr  = next_set[SET_W-1:VIS_BIT_W];
               state_in = S_LCHK;
            end
         end
         S_LCHK: begin
            if (out_free) begin
               pend_kind_in = KIND_TRANS;
               if (!v_rdata[next_set[VIS_BIT_W-1:0]]) begin
                  if (q_full) begin
                     pend_kind_in = KIND_OVF;
                  end else begin
                     q_push     = 1'b1;
                     q_we       = 1'b1;
                     q_waddr    = q_tail_ff;
                     q_wdata    = next_set;
                     q_tail_in  = (q_tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 :
                                  q_tail_ff + QW'(1);
                     q_count_in = q_count_ff + QCW'(1);
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{kind: pend_kind_in, from_set: cur_ff,
                                edge_letter: letter_ff[li_ff[LW-1:0]],
                                to_set: next_set,
                                from_is_final: |(cur_ff & final_mask_ff),
                                last: 1'b0};
               li_in        = li_ff + LCW'(1);
               state_in     = S_LET;
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{kind: KIND_CLOSED, from_set: cur_ff, edge_letter: '0,
                                to_set: '0,
                                from_is_final: |(cur_ff & final_mask_ff),
                                last: 1'b1};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_SWEEP;
         start_state_ff  <= '0;
         final_mask_ff   <= '0;
         letter_count_ff <= '0;
         succ_vld_ff     <= '0;
         rd_vld_ff       <= 1'b0;
         q_head_ff       <= '0;
         q_tail_ff       <= '0;
         q_count_ff      <= '0;
         sweep_ff        <= '0;
         sweep_ack_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         start_state_ff  <= start_state_in;
         final_mask_ff   <= final_mask_in;
         letter_count_ff <= letter_count_in;
         succ_vld_ff     <= succ_vld_in;
         rd_vld_ff       <= rd_vld_in;
         q_head_ff       <= q_head_in;
         q_tail_ff       <= q_tail_in;
         q_count_ff      <= q_count_in;
         sweep_ff        <= sweep_in;
         sweep_ack_ff    <= sweep_ack_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      cur_ff       <= cur_in;
      s_ff         <= s_in;
      acc_ff       <= acc_in;
      li_ff        <= li_in;
      trn_bit_ff   <= trn_bit_in;
      trn_li_ff    <= trn_li_in;
      trn_from_ff  <= trn_from_in;
      rsp_data_ff  <= rsp_data_in;
      if (letter_we) begin
         letter_ff[letter_count_ff[LW-1:0]] <= req_data.letter_code;
      end
   end

   // successor rows, one per nfa state, all letters side by side
   nfa_ram #(.WIDTH(ROW_W), .DEPTH(NFA_STATES)) u_succ_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   // subset fifo storage
   nfa_ram #(.WIDTH(SET_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   // visited bitmap
   nfa_ram #(.WIDTH(VIS_ROW_W), .DEPTH(1 << VIS_AW)) u_vis_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_en   (v_re),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

`ifndef SYNTH
   a_qcount_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_letter_bound: assert property (@(posedge clock) disable iff (reset)
      letter_count_ff <= LCW'(LETTERS))
      else $error("letter count above alphabet size");

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (next_set != '0) && !q_full)
      else $error("empty or overflowing subset pushed");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.cmd == CMD_STEP && q_count_ff != '0) |=>
      (q_count_ff == $past(q_count_ff) - QCW'(1)) && (state_ff == S_POP))
      else $error("step pop did not update queue");

   a_no_emit_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |=> !(rsp_valid_ff && !$past(rsp_valid_ff)))
      else $error("result raised during clearing pass");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the nfa subset construction block
module testbench
   import nfa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_STATES  = 16;
   localparam int N_LETTERS = 8;
   localparam int Q_DEPTH   = 1024;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int TAIL_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_START_STATE;
   logic [SET_W-1:0] csr_wdata = '0;

   nfa_subset_construction i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow copy of the block state used by the predictor
   logic [3:0] pm_start;
   logic [15:0] pm_final;
   logic [7:0] pm_letters [N_LETTERS];
   int pm_letter_cnt;
   logic [15:0] pm_succ [N_STATES][N_LETTERS];
   bit pm_seen [int];
   logic [15:0] pm_queue [$];

   req_type cmd_pending [$];   // beats waiting for the driver
   rsp_type rsp_expected [$];  // results predicted, not yet seen
   int errors = 0;
   int cycles = 0;
   int n_beats_in = 0;
   int n_beats_out = 0;
   int n_trans = 0;
   int n_ovf = 0;
   int send_idle_pct = 17;
   int recv_idle_pct = 82;
   bit hold_off = 1'b0;

   // append helpers for the three queues
   function automatic void queue_rsp(rsp_type r);
      rsp_expected = {rsp_expected, r};
   endfunction

   function automatic void queue_cmd(req_type c);
      cmd_pending = {cmd_pending, c};
   endfunction

   function automatic void queue_subset(logic [15:0] s);
      pm_queue = {pm_queue, s};
   endfunction

   function automatic rsp_type mk_rsp(logic [2:0] kind, logic [15:0] from,
                                      logic [7:0] letter, logic [15:0] to, bit last);
      rsp_type r;
      r.kind = kind;
      r.from_set = from;
      r.edge_letter = letter;
      r.to_set = to;
      r.from_is_final = (from & pm_final) != 0;
      r.last = last;
      return r;
   endfunction

   function automatic int letter_slot(logic [7:0] code);
      for (int i = 0; i < pm_letter_cnt; i++)
         if (pm_letters[i] == code) return i;
      return -1;
   endfunction

   // works out the result beats for one accepted command beat
   task automatic predict_cmd(req_type c);
      int slot;
      logic [15:0] cur, nxt;
      logic [2:0] kind;
      case (c.cmd)
         CMD_CLEAR: begin
            foreach (pm_succ[s, l]) pm_succ[s][l] = '0;
            pm_letter_cnt = 0;
         end
         CMD_LETTER: begin
            if (letter_slot(c.letter_code) < 0) begin
               if (pm_letter_cnt >= N_LETTERS) begin
                  queue_rsp(mk_rsp(KIND_OVF, 0, 0, 0, 1));
                  return;
               end
               pm_letters[pm_letter_cnt] = c.letter_code;
               pm_letter_cnt++;
            end
         end
         CMD_TRANS: begin
            slot = letter_slot(c.letter_code);
            if (slot >= 0) pm_succ[c.from_state][slot] |= 16'(1) << c.to_state;
         end
         CMD_START: begin
            pm_seen.delete();
            pm_queue.delete();
            queue_subset(16'(1) << pm_start);
         end
         CMD_STEP: begin
            if (pm_queue.size() == 0) begin
               queue_rsp(mk_rsp(KIND_EMPTY, 0, 0, 0, 1));
               return;
            end
            cur = pm_queue.pop_front();
            if (pm_seen.exists(cur)) begin
               queue_rsp(mk_rsp(KIND_SKIPPED, cur, 0, 0, 1));
               return;
            end
            pm_seen[cur] = 1'b1;
            for (int l = 0; l < pm_letter_cnt; l++) begin
               nxt = '0;
               for (int s = 0; s < N_STATES; s++)
                  if (cur[s]) nxt |= pm_succ[s][l];
               if (nxt != 0) begin
                  kind = KIND_TRANS;
                  if (!pm_seen.exists(nxt)) begin
                     if (pm_queue.size() >= Q_DEPTH) kind = KIND_OVF;
                     else queue_subset(nxt);
                  end
                  queue_rsp(mk_rsp(kind, cur, pm_letters[l], nxt, 0));
               end
            end
            queue_rsp(mk_rsp(KIND_CLOSED, cur, 0, 0, 1));
            return;
         end
         default: ;
      endcase
      queue_rsp(mk_rsp(KIND_ACK, 0, 0, 0, 1));
   endtask

   task automatic report_mismatch(string what, rsp_type got, rsp_type exp);
      errors++;
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
   endtask

   // driver: one beat at a time from the pending queue, held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_cmd(req_data);
            n_beats_in++;
         end
         if (!req_valid || !req_stall) begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= cmd_pending.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_beats_out++;
            if (rsp_data.kind == KIND_TRANS) n_trans++;
            if (rsp_data.kind == KIND_OVF) n_ovf++;
            if (rsp_expected.size() == 0)
               report_mismatch("unexpected beat", rsp_data, '0);
            else begin
               rsp_type e;
               e = rsp_expected.pop_front();
               if (rsp_data.kind != e.kind) report_mismatch("kind", rsp_data, e);
               if (rsp_data.from_set != e.from_set) report_mismatch("from_set", rsp_data, e);
               if (rsp_data.edge_letter != e.edge_letter)
                  report_mismatch("edge_letter", rsp_data, e);
               if (rsp_data.to_set != e.to_set) report_mismatch("to_set", rsp_data, e);
               if (rsp_data.from_is_final != e.from_is_final)
                  report_mismatch("from_is_final", rsp_data, e);
               if (rsp_data.last != e.last) report_mismatch("last", rsp_data, e);
            end
         end
      end
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", rsp_expected.size());
         $display("simulation failed");
         $finish;
      end
   end

   // long receiver hold-off, counted in its own process
   initial begin
      int waited;
      @(posedge clock iff n_beats_in > 60);
      hold_off = 1'b1;
      waited = 0;
      while (waited < 400) begin
         @(posedge clock);
         waited++;
      end
      hold_off = 1'b0;
   end

   function automatic req_type mk_cmd(logic [2:0] cmd, logic [7:0] code,
                                      logic [3:0] from, logic [3:0] to);
      req_type c;
      c.cmd = cmd;
      c.letter_code = code;
      c.from_state = from;
      c.to_state = to;
      return c;
   endfunction

   // waits until the block has drained, then writes one register
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      @(posedge clock iff (cmd_pending.size() == 0 && !req_valid
                           && rsp_expected.size() == 0));
      repeat (TAIL_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_START_STATE) pm_start = value[3:0];
      else pm_final = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random automaton loaded then explored; a few noise beats mixed in
   task automatic queue_random_nfa(int n_letters, int n_trans_add, int n_steps);
      logic [7:0] codes [16];
      for (int i = 0; i < 16; i++) codes[i] = 8'($urandom);
      queue_cmd(mk_cmd(CMD_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom)));
      for (int i = 0; i < n_letters; i++)
         queue_cmd(mk_cmd(CMD_LETTER, codes[i], 4'($urandom), 4'($urandom)));
      for (int i = 0; i < n_trans_add; i++)
         queue_cmd(mk_cmd(CMD_TRANS,
            ($urandom_range(9) == 0) ? 8'($urandom) : codes[$urandom_range(n_letters)],
            4'($urandom), 4'($urandom)));
      queue_cmd(mk_cmd(CMD_START, 8'($urandom), 4'($urandom), 4'($urandom)));
      for (int i = 0; i < n_steps; i++)
         queue_cmd(mk_cmd(($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                          : CMD_STEP, 8'($urandom), 4'($urandom), 4'($urandom)));
   endtask

   initial begin
      pm_start = '0;
      pm_final = '0;
      pm_letter_cnt = 0;
      foreach (pm_succ[s, l]) pm_succ[s][l] = '0;
      foreach (pm_letters[i]) pm_letters[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, extremes, duplicate and overflowing letters
      write_csr(CSR_START_STATE, 16'd15);
      write_csr(CSR_FINAL_MASK, 16'hFFFF);
      queue_cmd(mk_cmd(CMD_STEP, 8'hFF, 4'hF, 4'hF));
      for (int i = 0; i < 9; i++)
         queue_cmd(mk_cmd(CMD_LETTER, (i == 0) ? 8'h00 : 8'hF0 + 8'(i), 0, 0));
      queue_cmd(mk_cmd(CMD_LETTER, 8'h00, 0, 0));        // duplicate
      queue_cmd(mk_cmd(CMD_TRANS, 8'h00, 4'hF, 4'h0));
      queue_cmd(mk_cmd(CMD_TRANS, 8'h00, 4'h0, 4'hF));
      queue_cmd(mk_cmd(CMD_TRANS, 8'hF8, 4'hF, 4'hF));
      queue_cmd(mk_cmd(CMD_TRANS, 8'h55, 4'h1, 4'h2));   // unknown letter
      queue_cmd(mk_cmd(CMD_START, 0, 0, 0));
      for (int i = 0; i < 5; i++) queue_cmd(mk_cmd(CMD_STEP, 0, 0, 0));
      queue_cmd(mk_cmd(3'd7, 8'hAA, 4'h5, 4'hA));        // undefined command
      queue_cmd(mk_cmd(3'd5, 8'h55, 4'hA, 4'h5));

      write_csr(CSR_START_STATE, 16'd0);
      write_csr(CSR_FINAL_MASK, 16'h0000);
      queue_random_nfa(3, 20, 25);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 82 : 0;
         recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 17 : 0;
         for (int k = 0; k < 2; k++) begin
            write_csr(CSR_START_STATE, 16'($urandom_range(15)));
            write_csr(CSR_FINAL_MASK, 16'($urandom));
            queue_random_nfa($urandom_range(1, 8), $urandom_range(10, 30), 25);
         end
      end

      @(posedge clock iff (cmd_pending.size() == 0 && !req_valid
                           && rsp_expected.size() == 0));
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d command beats, %0d result beats (%0d transitions, %0d overflows)",
               n_beats_in, n_beats_out, n_trans, n_ovf);
      $display("covered loading, start, steps, skips, empty queue and full alphabet");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
